// ===== rtl/scrd_pkg.sv =====
// shared widths, constants and types for the star catalog record decoder
`default_nettype none

package scrd_pkg;

    localparam int RA_W      = 27;
    localparam int DEC_W     = 26;
    localparam int MAG_W     = 32;
    localparam int MAGOUT_W  = 9;
    localparam int MAG_ABS_W = 8;
    localparam int LIMIT_W   = 8;

    localparam logic [RA_W-1:0]         RA_FULL    = 27'd129600000;
    localparam logic [DEC_W-1:0]        DEC_SAT_IN = 26'd64800000;
    localparam logic [DEC_W:0]          DEC_OFFSET = 27'd32400000;
    localparam logic signed [DEC_W-1:0] DEC_MAX    = 26'sd32400000;

    // b = m mod 1e6 is found as ((m >> 6) mod 15625) << 6 | m[5:0]
    localparam int B_LOW_W   = 6;
    localparam int B_XW      = 26;
    localparam int B_QW      = 12;
    localparam int B_DIVISOR = 15625;
    localparam int B_SHIFT   = 36;
    localparam int B_W       = 20;

    // b / 1000 and b mod 1000 via (b >> 3) / 125
    localparam int R_LOW_W   = 3;
    localparam int R_XW      = 17;
    localparam int R_QW      = 10;
    localparam int R_DIVISOR = 125;
    localparam int R_SHIFT   = 24;
    localparam int R_W       = 10;

    // flag digit of one: millions quotient in [1000, 2000)
    localparam logic [B_QW-1:0] FLAG_ONE_LO = 12'd1000;
    localparam logic [B_QW-1:0] FLAG_ONE_HI = 12'd2000;

    localparam logic [B_W-1:0]       BLUE_TOP     = 20'd251000;
    localparam logic [R_W-1:0]       RED_TOP      = 10'd251;
    localparam logic [MAG_ABS_W-1:0] MAG_BAD      = 8'd215;
    localparam logic [MAG_ABS_W-1:0] MAG_ZERO     = 8'd214;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET  = 8'd100;
    localparam logic [LIMIT_W:0]     LIMIT_MARGIN = 9'd5;

    typedef struct packed {
        logic [RA_W-1:0]         ra;
        logic signed [DEC_W-1:0] dec;
    } coord_t;

    typedef struct packed {
        logic [R_LOW_W-1:0] b_low;
        logic               b_zero;
        logic               b_in_band;
        logic               neg;
        coord_t             coord;
    } mag_side_t;

endpackage

`default_nettype wire

// ===== rtl/scrd_const_div.sv =====
// three-stage divide by a constant: reciprocal multiply, back-multiply, one correction
`default_nettype none

module scrd_const_div #(
    parameter int XW      = 26,
    parameter int QW      = 12,
    parameter int DIVISOR = 15625,
    parameter int SHIFT   = 36,
    parameter int SW      = 1
) (
    input  wire logic                         clk,
    input  wire logic [2:0]                   adv,
    input  wire logic [XW-1:0]                x,
    input  wire logic [SW-1:0]                side_in,
    output logic [QW-1:0]                     q,
    output logic [$clog2(DIVISOR)-1:0]        rem,
    output logic [SW-1:0]                     side_out
);

    localparam int          RW    = $clog2(DIVISOR);
    localparam logic [63:0] KFULL = (64'd1 << SHIFT) / 64'(DIVISOR);
    localparam int          KW    = $clog2(KFULL + 64'd1);
    localparam logic [KW-1:0]    RECIP = KFULL[KW-1:0];
    localparam logic [RW:0]      DIV_R = (RW+1)'(DIVISOR);
    localparam logic [QW+RW-1:0] DIV_M = (QW+RW)'(DIVISOR);

    logic [XW+KW-1:0] prod_reg;
    logic [XW+KW-1:0] prod_next;
    logic [XW-1:0]    x1_reg;
    logic [SW-1:0]    s1_reg;

    logic [QW-1:0]    q_est;
    logic [QW+RW-1:0] back_prod;
    logic [XW-1:0]    diff;
    logic [QW-1:0]    qe_reg;
    logic [RW:0]      rem0_reg;
    logic [RW:0]      rem0_next;
    logic [SW-1:0]    s2_reg;

    logic [QW-1:0]    q_reg;
    logic [QW-1:0]    q_next;
    logic [RW-1:0]    rem_reg;
    logic [RW-1:0]    rem_next;
    logic [SW-1:0]    s3_reg;

    // estimate is exact or one low
    assign prod_next = {{KW{1'b0}}, x} * {{XW{1'b0}}, RECIP};

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            prod_reg <= prod_next;
            x1_reg   <= x;
            s1_reg   <= side_in;
        end
    end

    assign q_est     = prod_reg[SHIFT+QW-1:SHIFT];
    assign back_prod = {{RW{1'b0}}, q_est} * DIV_M;
    assign diff      = x1_reg - XW'(back_prod);
    assign rem0_next = diff[RW:0];

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            qe_reg   <= q_est;
            rem0_reg <= rem0_next;
            s2_reg   <= s1_reg;
        end
    end

    always_comb
    begin
        if (rem0_reg >= DIV_R)
        begin
            q_next   = qe_reg + QW'(1);
            rem_next = RW'(rem0_reg - DIV_R);
        end
        else
        begin
            q_next   = qe_reg;
            rem_next = rem0_reg[RW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
            s3_reg  <= s2_reg;
        end
    end

    assign q        = q_reg;
    assign rem      = rem_reg;
    assign side_out = s3_reg;

endmodule

`default_nettype wire

// ===== rtl/scrd_mag_class.sv =====
// final stage: magnitude band checks, sign, limit compare and output register
`default_nettype none

module scrd_mag_class (
    input  wire logic                                 clk,
    input  wire logic                                 adv,
    input  wire logic [scrd_pkg::R_QW-1:0]            blue_q,
    input  wire logic [scrd_pkg::R_W-1:0]             red_r,
    input  wire scrd_pkg::mag_side_t                  side,
    input  wire logic [scrd_pkg::LIMIT_W-1:0]         limit,
    output logic [scrd_pkg::RA_W-1:0]                 ra_centiarcsec,
    output logic signed [scrd_pkg::DEC_W-1:0]         dec_centiarcsec,
    output logic signed [scrd_pkg::MAGOUT_W-1:0]      blue_mag,
    output logic signed [scrd_pkg::MAGOUT_W-1:0]      red_mag,
    output logic                                      beyond_limit
);

    import scrd_pkg::*;

    logic [MAG_ABS_W-1:0]       blue_abs;
    logic [MAG_ABS_W-1:0]       red_abs;
    logic [MAGOUT_W-1:0]        blue_ext;
    logic [MAGOUT_W-1:0]        red_ext;
    logic [LIMIT_W:0]           stop_level;

    logic [RA_W-1:0]            ra_reg;
    logic signed [DEC_W-1:0]    dec_reg;
    logic [MAGOUT_W-1:0]        blue_reg;
    logic [MAGOUT_W-1:0]        blue_next;
    logic [MAGOUT_W-1:0]        red_reg;
    logic [MAGOUT_W-1:0]        red_next;
    logic                       beyond_reg;
    logic                       beyond_next;

    always_comb
    begin
        if (!side.b_in_band || side.b_zero)
            blue_abs = MAG_BAD;
        else if (blue_q == '0)
            blue_abs = MAG_ZERO;
        else
            blue_abs = blue_q[MAG_ABS_W-1:0];

        if (red_r != '0 && red_r < RED_TOP)
            red_abs = red_r[MAG_ABS_W-1:0];
        else
            red_abs = MAG_BAD;
    end

    assign blue_ext    = {1'b0, blue_abs};
    assign red_ext     = {1'b0, red_abs};
    assign blue_next   = side.neg ? (~blue_ext + MAGOUT_W'(1)) : blue_ext;
    assign red_next    = side.neg ? (~red_ext + MAGOUT_W'(1)) : red_ext;
    assign stop_level  = {1'b0, limit} + LIMIT_MARGIN;
    assign beyond_next = blue_ext > stop_level;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ra_reg     <= side.coord.ra;
            dec_reg    <= side.coord.dec;
            blue_reg   <= blue_next;
            red_reg    <= red_next;
            beyond_reg <= beyond_next;
        end
    end

    assign ra_centiarcsec  = ra_reg;
    assign dec_centiarcsec = dec_reg;
    assign blue_mag        = blue_reg;
    assign red_mag         = red_reg;
    assign beyond_limit    = beyond_reg;

endmodule

`default_nettype wire

// ===== rtl/star_catalog_record_decoder.sv =====
// star catalog record decoder: eight-stage pipeline from 12-byte record to fields
//
// input request: in_valid/in_ready with ra_word, dec_word, mag_word (one record)
// output request: out_valid/out_ready with ra_centiarcsec, dec_centiarcsec,
//   blue_mag, red_mag, beyond_limit (one result per record, same order)
// config: cfg_wr_en writes cfg_wr_data into the magnitude limit at once
// a taken record passes stage 0, both divider pipelines and the classify
//   stage; out_valid rises once it sits in the output register
// throughput: one record per cycle unless out_ready stalls; two reciprocal
//   multiply dividers (three stages each) sit between saturation and classify
// each stage holds its own valid bit and advances when the next is empty
//   or moving, so bubbles close up and in_ready stays high while any
//   stage is free
// when the receiver stalls, the output register holds its result and the
//   stages behind it fill, then in_ready drops; nothing is lost or repeated
// reset empties every stage and sets the limit to 100 tenths
`default_nettype none

module star_catalog_record_decoder (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [scrd_pkg::RA_W-1:0]            ra_word,
    input  wire logic [scrd_pkg::DEC_W-1:0]           dec_word,
    input  wire logic [scrd_pkg::MAG_W-1:0]           mag_word,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [scrd_pkg::RA_W-1:0]                 ra_centiarcsec,
    output logic signed [scrd_pkg::DEC_W-1:0]         dec_centiarcsec,
    output logic signed [scrd_pkg::MAGOUT_W-1:0]      blue_mag,
    output logic signed [scrd_pkg::MAGOUT_W-1:0]      red_mag,
    output logic                                      beyond_limit,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [scrd_pkg::LIMIT_W-1:0]         cfg_wr_data
);

    import scrd_pkg::*;

    localparam int DEPTH = 8;
    localparam int SW1   = B_LOW_W + $bits(coord_t);
    localparam int SW2   = $bits(mag_side_t);
    localparam int RW1   = $clog2(B_DIVISOR);
    localparam int RW2   = $clog2(R_DIVISOR);

    logic [DEPTH-1:0]   vld_reg;
    logic [DEPTH-1:0]   vld_next;
    logic [DEPTH-1:0]   adv;
    logic [LIMIT_W-1:0] limit_reg;
    logic [LIMIT_W-1:0] limit_next;

    // stage 0: absolute value and coordinate saturation
    logic [MAG_W-1:0]   abs_next;
    logic [RA_W-1:0]    ra_next;
    logic [DEC_W:0]     dec_diff;
    logic [DEC_W-1:0]   dec_next;
    logic [MAG_W-1:0]   abs_reg;
    coord_t             coord_reg;

    logic [SW1-1:0]     side1_in;
    logic [SW1-1:0]     side1_out;
    logic [B_QW-1:0]    q1;
    logic [RW1-1:0]     rem1;
    logic [B_W-1:0]     b_val;
    coord_t             coord1;

    mag_side_t          side2_in;
    logic [SW2-1:0]     side2_out;
    logic [R_QW-1:0]    q2;
    logic [RW2-1:0]     rem2;
    mag_side_t          side2;
    logic [R_W-1:0]     red_r;

    always_comb
    begin
        adv[DEPTH-1] = !vld_reg[DEPTH-1] || out_ready;
        for (int k = DEPTH - 2; k >= 0; k--)
            adv[k] = !vld_reg[k] || adv[k+1];
    end

    always_comb
    begin
        vld_next[0] = adv[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < DEPTH; k++)
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
    end

    assign limit_next = cfg_wr_en ? cfg_wr_data : limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            vld_reg   <= vld_next;
            limit_reg <= limit_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[DEPTH-1];

    // 0x80000000 negates to itself, read as 2^31
    assign abs_next = mag_word[MAG_W-1] ? (~mag_word + MAG_W'(1)) : mag_word;
    assign ra_next  = (ra_word > RA_FULL) ? RA_FULL : ra_word;
    assign dec_diff = {1'b0, dec_word} - DEC_OFFSET;
    assign dec_next = (dec_word > DEC_SAT_IN) ? DEC_MAX : dec_diff[DEC_W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            abs_reg         <= abs_next;
            coord_reg.ra    <= ra_next;
            coord_reg.dec   <= dec_next;
        end
    end

    // stages 1-3: millions quotient and remainder
    assign side1_in = {abs_reg[B_LOW_W-1:0], coord_reg};

    scrd_const_div #(
        .XW      (B_XW),
        .QW      (B_QW),
        .DIVISOR (B_DIVISOR),
        .SHIFT   (B_SHIFT),
        .SW      (SW1)
    ) u_div_million (
        .clk      (clk),
        .adv      (adv[3:1]),
        .x        (abs_reg[MAG_W-1:B_LOW_W]),
        .side_in  (side1_in),
        .q        (q1),
        .rem      (rem1),
        .side_out (side1_out)
    );

    assign coord1 = side1_out[$bits(coord_t)-1:0];
    assign b_val  = {rem1, side1_out[SW1-1:$bits(coord_t)]};

    always_comb
    begin
        side2_in.b_low     = b_val[R_LOW_W-1:0];
        side2_in.b_zero    = (b_val == '0);
        side2_in.b_in_band = (b_val <= BLUE_TOP);
        side2_in.neg       = (q1 >= FLAG_ONE_LO) && (q1 < FLAG_ONE_HI);
        side2_in.coord     = coord1;
    end

    // stages 4-6: thousands quotient and remainder
    scrd_const_div #(
        .XW      (R_XW),
        .QW      (R_QW),
        .DIVISOR (R_DIVISOR),
        .SHIFT   (R_SHIFT),
        .SW      (SW2)
    ) u_div_thousand (
        .clk      (clk),
        .adv      (adv[6:4]),
        .x        (b_val[B_W-1:R_LOW_W]),
        .side_in  (side2_in),
        .q        (q2),
        .rem      (rem2),
        .side_out (side2_out)
    );

    assign side2 = side2_out;
    assign red_r = {rem2, side2.b_low};

    // stage 7: classify and output register
    scrd_mag_class u_mag_class (
        .clk             (clk),
        .adv             (adv[7]),
        .blue_q          (q2),
        .red_r           (red_r),
        .side            (side2),
        .limit           (limit_reg),
        .ra_centiarcsec  (ra_centiarcsec),
        .dec_centiarcsec (dec_centiarcsec),
        .blue_mag        (blue_mag),
        .red_mag         (red_mag),
        .beyond_limit    (beyond_limit)
    );

`ifndef NO_ASSERTIONS
    // a draining output frees the whole pipe
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("in_ready low while output drains");

    // taken request shows up in stage 0
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
        else $error("accepted request lost at stage 0");

    // blue reaches 251 at the top of the band
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> blue_mag != '0 && blue_mag <= 9'sd251 && blue_mag >= -9'sd251)
        else $error("blue magnitude out of band");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> red_mag != '0 && red_mag <= 9'sd250 && red_mag >= -9'sd250)
        else $error("red magnitude out of band");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ra_centiarcsec <= RA_FULL
            && dec_centiarcsec <= DEC_MAX && dec_centiarcsec >= -DEC_MAX)
        else $error("coordinate not saturated");
`endif

endmodule

`default_nettype wire
